>>> hdl/pfc_pkg.sv
// shared types and constants for the packet filter classifier
package pfc_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int HOOK_POINTS_DEF = 5;

  localparam logic [1:0] KIND_CLASSIFY = 2'd0;
  localparam logic [1:0] KIND_SET      = 2'd1;
  localparam logic [1:0] KIND_REMOVE   = 2'd2;

  localparam int CK_PROTO = 0;
  localparam int CK_OUT   = 1;
  localparam int CK_IN    = 2;
  localparam int CK_SADDR = 3;
  localparam int CK_DADDR = 4;
  localparam int CK_SPORT = 5;
  localparam int CK_DPORT = 6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [2:0]  hook;
    logic [7:0]  in_if;
    logic [7:0]  out_if;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        has_ip;
    logic        has_tcp;
  } pfc_item_t;

  typedef struct packed {
    logic       status;
    logic       matched;
    logic [3:0] match_slot;
  } pfc_result_t;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SEND} pfc_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic show;
  } pfc_cmd_t;
endpackage

>>> hdl/pfc_if.sv
// valid/ready channel interfaces for items and results
interface pfc_in_if import pfc_pkg::*; ();
  logic      valid;
  logic      ready;
  pfc_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
  logic        valid;
  logic        ready;
  pfc_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/packet_filter_classifier.sv
// top level of the five-tuple packet filter classifier
//
//   channel   dir  payload
//   in_*      in   kind, slot, hook, ifaces, proto, addrs, ports, has_ip, has_tcp
//   out_*     out  status, matched, match_slot
//
// each item passes through accept, the table compare and rank update, then
// the result transfer; a new item is taken after that.
// reset synchronously clears valid bits and ranks; entry contents have no reset.
// a stalled result holds in its register and blocks the next accept.
module packet_filter_classifier import pfc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int HOOK_POINTS = HOOK_POINTS_DEF
) (
  input logic clk,
  input logic rst_n,
  pfc_in_if.sink    in_ch,
  pfc_out_if.source out_ch
);
  pfc_cmd_t cmd;

  pfc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd)
  );

  pfc_datapath #(.ENTRIES(ENTRIES), .HOOK_POINTS(HOOK_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .item(in_ch.data), .result(out_ch.data)
  );
endmodule

>>> hdl/pfc_ctrl.sv
// controller sequencing accept, execute and result transfer
module pfc_ctrl import pfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pfc_cmd_t cmd
);
  pfc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_SEND;
      ST_SEND: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_SEND);
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.exec  = (state_r == ST_EXEC);
    cmd.show  = (state_r == ST_SEND);
  end
endmodule

>>> hdl/pfc_datapath.sv
// filter table, parallel match and rank bookkeeping
module pfc_datapath import pfc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int HOOK_POINTS = HOOK_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pfc_cmd_t    cmd,
  input  pfc_item_t   item,
  output pfc_result_t result
);
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  pfc_item_t   item_r;
  pfc_result_t res_r, res_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [RW-1:0] rank_r [ENTRIES];
  logic [RW-1:0] rank_nxt [ENTRIES];
  logic [2:0]  e_hook [ENTRIES];
  logic [6:0]  e_chk [ENTRIES];
  logic [7:0]  e_in [ENTRIES];
  logic [7:0]  e_out [ENTRIES];
  logic [7:0]  e_proto [ENTRIES];
  logic [31:0] e_sa [ENTRIES];
  logic [31:0] e_da [ENTRIES];
  logic [15:0] e_sp [ENTRIES];
  logic [15:0] e_dp [ENTRIES];

  logic [ENTRIES-1:0] hit;
  logic slot_ok, hook_ok, do_set, do_drop;
  logic [RW-1:0] slot_ix;
  logic [6:0] chk_new;

  assign slot_ok = ({28'd0, item_r.slot} < 32'(ENTRIES));
  assign hook_ok = ({29'd0, item_r.hook} < 32'(HOOK_POINTS));
  assign slot_ix = RW'(item_r.slot);
  assign do_set  = (item_r.kind == KIND_SET) && hook_ok && slot_ok;
  assign do_drop = ((item_r.kind == KIND_REMOVE) && slot_ok) || do_set;

  always_comb begin
    chk_new = '0;
    chk_new[CK_PROTO] = item_r.proto != '0;
    chk_new[CK_OUT]   = item_r.out_if != '0;
    chk_new[CK_IN]    = item_r.in_if != '0;
    chk_new[CK_SADDR] = item_r.src_addr != '0;
    chk_new[CK_DADDR] = item_r.dst_addr != '0;
    chk_new[CK_SPORT] = item_r.src_port != '0;
    chk_new[CK_DPORT] = item_r.dst_port != '0;
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = valid_r[i] && (e_hook[i] == item_r.hook)
        && !(e_chk[i][CK_OUT] && e_out[i] != item_r.out_if)
        && !(e_chk[i][CK_IN] && e_in[i] != item_r.in_if)
        && !(item_r.has_ip && e_chk[i][CK_PROTO] && e_proto[i] != item_r.proto)
        && !(item_r.has_ip && e_chk[i][CK_SADDR] && e_sa[i] != item_r.src_addr)
        && !(item_r.has_ip && e_chk[i][CK_DADDR] && e_da[i] != item_r.dst_addr)
        && !(item_r.has_tcp && e_chk[i][CK_SPORT] && e_sp[i] != item_r.src_port)
        && !(item_r.has_tcp && e_chk[i][CK_DPORT] && e_dp[i] != item_r.dst_port);
    end
  end

  // valid ranks are distinct, so the newest hit is the one whose rank is
  // lower than every other hit
  always_comb begin
    logic drop_v;
    logic [RW-1:0] drop_rank;
    res_nxt = '0;
    drop_v = do_drop && valid_r[slot_ix];
    drop_rank = rank_r[slot_ix];
    valid_nxt = valid_r;
    for (int i = 0; i < ENTRIES; i++) rank_nxt[i] = rank_r[i];
    case (item_r.kind)
      KIND_CLASSIFY: begin
        for (int i = 0; i < ENTRIES; i++) begin
          logic best;
          best = hit[i];
          for (int j = 0; j < ENTRIES; j++)
            if (j != i && hit[j] && rank_r[j] < rank_r[i]) best = 1'b0;
          if (best) begin
            res_nxt.matched = 1'b1;
            res_nxt.match_slot = 4'(i);
          end
        end
      end
      KIND_SET, KIND_REMOVE: begin
        if (item_r.kind == KIND_SET && !hook_ok) res_nxt.status = 1'b1;
        if (drop_v) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid_r[i] && i != 32'(slot_ix) && rank_r[i] > drop_rank)
              rank_nxt[i] = rank_r[i] - 1'b1;
          valid_nxt[slot_ix] = 1'b0;
          rank_nxt[slot_ix] = '0;
        end
        if (do_set) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid_nxt[i]) rank_nxt[i] = rank_nxt[i] + 1'b1;
          valid_nxt[slot_ix] = 1'b1;
          rank_nxt[slot_ix] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
    if (cmd.exec) begin
      res_r <= res_nxt;
      if (do_set) begin
        e_hook[slot_ix]  <= item_r.hook;
        e_chk[slot_ix]   <= chk_new;
        e_in[slot_ix]    <= item_r.in_if;
        e_out[slot_ix]   <= item_r.out_if;
        e_proto[slot_ix] <= item_r.proto;
        e_sa[slot_ix]    <= item_r.src_addr;
        e_da[slot_ix]    <= item_r.dst_addr;
        e_sp[slot_ix]    <= item_r.src_port;
        e_dp[slot_ix]    <= item_r.dst_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  always_comb begin
    result = res_r;
    if (!cmd.show) result = res_r;
  end
endmodule

>>> dv/pfc_tb_if.sv
// testbench-side note: channel interfaces come from the rtl; this file holds item helpers
package pfc_tb_pkg;
  import pfc_pkg::*;

  // builds an item of the given kind with all other fields cleared
  function automatic pfc_item_t blank_item(logic [1:0] k);
    pfc_item_t it;
    it = '0;
    it.kind = k;
    return it;
  endfunction
endpackage

>>> dv/packet_filter_classifier_tb.sv
// self-checking testbench for the packet filter classifier: table writes, removes, classify
module packet_filter_classifier_tb;
  import pfc_pkg::*;
  import pfc_tb_pkg::*;

  localparam int N_ENT = ENTRIES_DEF;
  localparam int N_HOOK = HOOK_POINTS_DEF;

  logic clk;
  logic rst_n;
  pfc_in_if in_ch ();
  pfc_out_if out_ch ();

  packet_filter_classifier dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predicted table
  logic        tbl_valid [N_ENT];
  logic [2:0]  tbl_hook  [N_ENT];
  logic [6:0]  tbl_checks[N_ENT];
  logic [7:0]  tbl_inif  [N_ENT];
  logic [7:0]  tbl_outif [N_ENT];
  logic [7:0]  tbl_proto [N_ENT];
  logic [31:0] tbl_saddr [N_ENT];
  logic [31:0] tbl_daddr [N_ENT];
  logic [15:0] tbl_sport [N_ENT];
  logic [15:0] tbl_dport [N_ENT];
  int          tbl_age   [N_ENT];

  pfc_result_t verdict_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void drop_slot(int s);
    if (!tbl_valid[s]) return;
    for (int i = 0; i < N_ENT; i++)
      if (tbl_valid[i] && i != s && tbl_age[i] > tbl_age[s]) tbl_age[i]--;
    tbl_valid[s] = 1'b0;
    tbl_age[s] = 0;
  endfunction

  function automatic logic slot_hits(int s, pfc_item_t it);
    logic [6:0] c;
    c = tbl_checks[s];
    if (tbl_hook[s] != it.hook) return 0;
    if (c[CK_OUT] && tbl_outif[s] != it.out_if) return 0;
    if (c[CK_IN] && tbl_inif[s] != it.in_if) return 0;
    if (it.has_ip) begin
      if (c[CK_PROTO] && tbl_proto[s] != it.proto) return 0;
      if (c[CK_SADDR] && tbl_saddr[s] != it.src_addr) return 0;
      if (c[CK_DADDR] && tbl_daddr[s] != it.dst_addr) return 0;
    end
    if (it.has_tcp) begin
      if (c[CK_SPORT] && tbl_sport[s] != it.src_port) return 0;
      if (c[CK_DPORT] && tbl_dport[s] != it.dst_port) return 0;
    end
    return 1;
  endfunction

  function automatic pfc_result_t classify_step(pfc_item_t it);
    pfc_result_t r;
    int best;
    logic found;
    r = '0;
    best = 0;
    found = 1'b0;
    if (it.kind == KIND_CLASSIFY) begin
      for (int i = 0; i < N_ENT; i++)
        if (tbl_valid[i] && slot_hits(i, it)) begin
          if (!found || tbl_age[i] < tbl_age[best]) best = i;
          found = 1'b1;
        end
      r.matched = found;
      r.match_slot = found ? best[3:0] : 4'd0;
    end else if (it.kind == KIND_SET) begin
      if (32'(it.hook) >= N_HOOK) r.status = 1'b1;
      else if (32'(it.slot) < N_ENT) begin
        drop_slot(32'(it.slot));
        for (int i = 0; i < N_ENT; i++) if (tbl_valid[i]) tbl_age[i]++;
        tbl_valid[it.slot] = 1'b1;
        tbl_age[it.slot] = 0;
        tbl_hook[it.slot] = it.hook;
        tbl_checks[it.slot] = '0;
        tbl_checks[it.slot][CK_IN] = it.in_if != 0;
        tbl_checks[it.slot][CK_OUT] = it.out_if != 0;
        tbl_checks[it.slot][CK_SADDR] = it.src_addr != 0;
        tbl_checks[it.slot][CK_DADDR] = it.dst_addr != 0;
        tbl_checks[it.slot][CK_SPORT] = it.src_port != 0;
        tbl_checks[it.slot][CK_DPORT] = it.dst_port != 0;
        tbl_checks[it.slot][CK_PROTO] = it.proto != 0;
        tbl_inif[it.slot] = it.in_if;
        tbl_outif[it.slot] = it.out_if;
        tbl_proto[it.slot] = it.proto;
        tbl_saddr[it.slot] = it.src_addr;
        tbl_daddr[it.slot] = it.dst_addr;
        tbl_sport[it.slot] = it.src_port;
        tbl_dport[it.slot] = it.dst_port;
      end
    end else if (it.kind == KIND_REMOVE) begin
      if (32'(it.slot) < N_ENT) drop_slot(32'(it.slot));
    end
    return r;
  endfunction

  // valid stays high after a transfer until the next item or the drain drops it
  task automatic send_item(pfc_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    verdict_q.push_back(classify_step(it));
  endtask

  // receiver stalls and result check
  always @(posedge clk) begin
    pfc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, out_ch.data);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (want.status !== out_ch.data.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_ch.data.status);
          errors++;
        end
        if (want.matched !== out_ch.data.matched) begin
          $display("%0t: matched expected %0d actual %0d", $time, want.matched,
                   out_ch.data.matched);
          errors++;
        end
        if (want.match_slot !== out_ch.data.match_slot) begin
          $display("%0t: match_slot expected %0d actual %0d", $time, want.match_slot,
                   out_ch.data.match_slot);
          errors++;
        end
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // field values biased toward entries already in the table
  function automatic pfc_item_t rand_packet();
    pfc_item_t it;
    int s;
    it = '0;
    it.kind = KIND_CLASSIFY;
    it.hook = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                       : 3'($urandom_range(N_HOOK - 1));
    it.in_if = 8'($urandom); it.out_if = 8'($urandom); it.proto = 8'($urandom);
    it.src_addr = $urandom; it.dst_addr = $urandom;
    it.src_port = 16'($urandom); it.dst_port = 16'($urandom);
    it.has_ip = 1'($urandom); it.has_tcp = 1'($urandom);
    s = $urandom_range(N_ENT - 1);
    if (tbl_valid[s] && $urandom_range(3) != 0) begin
      it.hook = tbl_hook[s];
      if ($urandom_range(4) != 0) it.in_if = tbl_inif[s];
      if ($urandom_range(4) != 0) it.out_if = tbl_outif[s];
      if ($urandom_range(4) != 0) it.proto = tbl_proto[s];
      if ($urandom_range(4) != 0) it.src_addr = tbl_saddr[s];
      if ($urandom_range(4) != 0) it.dst_addr = tbl_daddr[s];
      if ($urandom_range(4) != 0) it.src_port = tbl_sport[s];
      if ($urandom_range(4) != 0) it.dst_port = tbl_dport[s];
    end
    return it;
  endfunction

  function automatic pfc_item_t rand_entry();
    pfc_item_t it;
    it = rand_packet();
    it.kind = KIND_SET;
    it.slot = 4'($urandom_range(N_ENT - 1));
    // zero fields act as wildcards, so make them common
    if ($urandom_range(1) != 0) it.in_if = '0;
    if ($urandom_range(1) != 0) it.out_if = '0;
    if ($urandom_range(1) != 0) it.proto = '0;
    if ($urandom_range(1) != 0) it.src_addr = '0;
    if ($urandom_range(1) != 0) it.dst_addr = '0;
    if ($urandom_range(1) != 0) it.src_port = '0;
    if ($urandom_range(1) != 0) it.dst_port = '0;
    return it;
  endfunction

  task automatic test_directed();
    pfc_item_t it;
    it = blank_item(KIND_CLASSIFY);
    send_item(it);                                // empty table
    it = blank_item(KIND_REMOVE); it.slot = 4'd3;
    send_item(it);                                // remove empty slot
    it = blank_item(KIND_SET); it.hook = 3'd5;
    send_item(it);                                // invalid hook refused
    it.hook = 3'd7; send_item(it);
    it = blank_item(KIND_SET); it.slot = 4'd0;
    send_item(it);                                // full wildcard at hook 0
    it = blank_item(KIND_SET); it.slot = 4'd15; it.hook = 3'd4;
    it.in_if = 8'hff; it.out_if = 8'hff; it.proto = 8'hff;
    it.src_addr = '1; it.dst_addr = '1; it.src_port = '1; it.dst_port = '1;
    send_item(it);
    it.kind = KIND_CLASSIFY; it.has_ip = 1'b1; it.has_tcp = 1'b1;
    send_item(it);                                // exact match
    it.src_port = 16'h0; send_item(it);           // port mismatch
    it.has_tcp = 1'b0; send_item(it);             // ports skipped
    it.proto = '0; it.has_ip = 1'b0; send_item(it);   // ip skipped
    it.in_if = '0; send_item(it);                 // iface always checked
    it = blank_item(KIND_CLASSIFY); it.hook = 3'd7;
    send_item(it);                                // hook beyond range
    it = blank_item(KIND_SET); it.slot = 4'd5;
    send_item(it);                                // newer wildcard
    it.kind = KIND_CLASSIFY; send_item(it);
    it.kind = KIND_SET; it.slot = 4'd0; send_item(it);   // overwrite valid slot
    it.kind = KIND_CLASSIFY; send_item(it);
    it.kind = KIND_REMOVE; send_item(it);
    it.kind = KIND_CLASSIFY; send_item(it);
    it = blank_item(2'd3); it.slot = 4'd5; send_item(it); // unused kind
    it = blank_item(KIND_CLASSIFY); send_item(it);
  endtask

  task automatic test_random(int n);
    pfc_item_t it;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) it = rand_packet();
      else if (pick < 80) it = rand_entry();
      else if (pick < 95) begin
        it = rand_packet();
        it.kind = KIND_REMOVE;
        it.slot = 4'($urandom_range(N_ENT - 1));
      end else begin
        it = rand_entry();
        it.kind = 2'($urandom_range(3));
        it.slot = 4'($urandom);
        it.hook = 3'($urandom);
      end
      send_item(it);
    end
  endtask

  task automatic drain();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (verdict_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < N_ENT; i++) begin
      tbl_valid[i] = 1'b0; tbl_age[i] = 0;
    end
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 6; recv_idle_pct = 49;
    test_random(510);
    send_idle_pct = 49; recv_idle_pct = 6;
    test_random(510);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(510);
    drain();
    if (errors == 0 && verdict_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> filelist.f
hdl/pfc_pkg.sv
hdl/pfc_if.sv
hdl/pfc_ctrl.sv
hdl/pfc_datapath.sv
hdl/packet_filter_classifier.sv
dv/pfc_tb_if.sv
dv/packet_filter_classifier_tb.sv
